FILE: hw/rtl/wtra_pkg.sv
// Shared codes and field widths for the wavelet tree rank/access unit.
// No dependencies; used by the unit, its checker and the bench.
`default_nettype none

package wtra_pkg;

    // Widths of the transaction fields
    localparam int KIND_W   = 2;
    localparam int SYM_W    = 4;
    localparam int POS_W    = 13;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 5;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    // Operation codes
    localparam t_kind KIND_APPEND = 2'd0;
    localparam t_kind KIND_BUILD  = 2'd1;
    localparam t_kind KIND_RANK   = 2'd2;
    localparam t_kind KIND_ACCESS = 2'd3;

    // Result status codes
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_BAD_SYM   = 3'd1;
    localparam t_status ST_BAD_POS   = 3'd2;
    localparam t_status ST_FULL      = 3'd3;
    localparam t_status ST_NOT_BUILT = 3'd4;

    // Alphabet size after reset
    localparam logic [CFG_W-1:0] ALPHA_RESET = 5'd4;

endpackage

`default_nettype wire

FILE: hw/rtl/wtra_node_walk.sv
// Walks a symbol down the alphabet splits of the wavelet tree to a given depth.
// Returns the low bound of the node reached and the branch bit taken there.
// Depends on nothing outside this file.
`default_nettype none

module wtra_node_walk #(
    parameter int VW     = 5,
    parameter int LEVELS = 4,
    parameter int DCW    = 3
) (
    input  wire logic [VW-1:0]  i_sym,
    input  wire logic [VW-1:0]  i_alpha,
    input  wire logic [DCW-1:0] i_depth,
    output logic      [VW-1:0]  o_lo,
    output logic                o_upper
);

    always_comb begin
        logic [VW-1:0] lo;
        logic [VW-1:0] hi;
        logic [VW-1:0] mid;
        lo = '0;
        hi = i_alpha;
        // one split per level above the requested depth
        for (int k = 0; k < LEVELS; k++) begin
            mid = VW'(({1'b0, lo} + {1'b0, hi}) >> 1);
            if ((DCW'(k) < i_depth) && ((hi - lo) >= VW'(2))) begin
                if (i_sym >= mid) begin
                    lo = mid;
                end else begin
                    hi = mid;
                end
            end
        end
        // branch bit of the node reached, zero at a leaf
        mid     = VW'(({1'b0, lo} + {1'b0, hi}) >> 1);
        o_upper = ((hi - lo) >= VW'(2)) && (i_sym >= mid);
        o_lo    = lo;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wavelet_tree_rank_access_unit.sv
// Top level of the wavelet tree rank/access unit: sequencer, symbol store and level store.
// Depends on wtra_pkg and wtra_node_walk.
//
// Symbols are appended one per transaction into a symbol store; a build transaction then
// writes one row per tree level into a level store, each entry holding the node bit and
// the running count of ones in that row before it, so a query never scans. Append,
// rejected items and a repeated build go from acceptance straight to the result state.
// A rank or access query walks down the tree one level at a time, with three reads of the
// level store per level (node start, start plus position, node end) and an update step.
// A build goes, per level, through every alphabet value; for each value that is the low
// bound of a node it makes one pass over the symbol store, writing one entry per symbol
// of that node, and it ends the row with the row total at index length. Each new item
// is accepted once the previous one is done; a finished result waits in the output
// register without holding up the next item; that item's result waits for a free register.
`default_nettype none

module wavelet_tree_rank_access_unit #(
    parameter int MAX_LENGTH   = 4096,
    parameter int MAX_ALPHABET = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // item channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [wtra_pkg::KIND_W-1:0]  i_kind,
    input  wire logic [wtra_pkg::SYM_W-1:0]   i_symbol,
    input  wire logic [wtra_pkg::POS_W-1:0]   i_position,
    // result channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [wtra_pkg::STATUS_W-1:0]     o_status,
    output logic [wtra_pkg::SYM_W-1:0]        o_symbol_found,
    output logic [wtra_pkg::POS_W-1:0]        o_count,
    // configuration channel
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [wtra_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int LEVELS    = $clog2(MAX_ALPHABET);
    localparam int DW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int DCW       = $clog2(LEVELS + 1);
    localparam int CW        = $clog2(MAX_LENGTH + 1);
    localparam int IW        = $clog2(MAX_LENGTH);
    localparam int AW        = $clog2(MAX_ALPHABET + 1);
    localparam int VW        = (AW > wtra_pkg::CFG_W) ? AW : wtra_pkg::CFG_W;
    localparam int SYW       = (MAX_ALPHABET > 2) ? $clog2(MAX_ALPHABET) : 1;
    localparam int PW        = (CW > wtra_pkg::POS_W) ? CW : wtra_pkg::POS_W;
    localparam int LA_W      = DW + CW;
    localparam int LVL_DEPTH = 1 << LA_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_B_NODE = 8'b0000_0010,
        S_B_SCAN = 8'b0000_0100,
        S_Q_RS   = 8'b0000_1000,
        S_Q_RP   = 8'b0001_0000,
        S_Q_RE   = 8'b0010_0000,
        S_Q_UPD  = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // control state
    logic [wtra_pkg::CFG_W-1:0] r_alpha_cfg;
    logic [CW-1:0]              r_len;
    logic                       r_built;
    logic [VW-1:0]              r_alpha_b;
    logic                       r_out_valid;
    logic                       r_rd_vld;

    // build and query datapath
    logic [VW-1:0]  r_v;
    logic [CW-1:0]  r_i, r_j, r_ones;
    logic [DCW-1:0] r_d, r_nlev;
    logic           r_q_rank;
    logic [VW-1:0]  r_q_sym, r_lo, r_hi;
    logic [CW-1:0]  r_p, r_s, r_e, r_ps, r_psp;
    logic           r_bsp;

    // result held until the output register is free
    logic [wtra_pkg::STATUS_W-1:0] r_res_status, r_out_status;
    logic [wtra_pkg::SYM_W-1:0]    r_res_found, r_out_found;
    logic [wtra_pkg::POS_W-1:0]    r_res_count, r_out_count;

    // memories
    logic [SYW-1:0] r_sym_mem [0:MAX_LENGTH-1];
    logic [SYW-1:0] r_sym_rdata;
    logic [CW:0]    r_lvl_mem [0:LVL_DEPTH-1];
    logic [CW:0]    r_lvl_rdata;

    logic              in_acc;
    logic [VW-1:0]     eff_alpha;
    logic [DCW-1:0]    nlev;
    logic [CW-1:0]     len0;
    logic              app_bad_sym, app_full, app_ok;
    logic              q_bad_sym, q_bad_pos, q_ok;
    logic [VW-1:0]     w_sym, w_lo;
    logic              w_upper;
    logic              row_end, last_level, emit, scan_more;
    logic              lvl_we;
    logic [LA_W-1:0]   lvl_waddr, lvl_raddr;
    logic [CW:0]       lvl_wdata;
    logic [VW-1:0]     q_mid, q_lo_n, q_hi_n;
    logic              q_bit, q_done;
    logic [CW-1:0]     q_ones, q_zeros, q_p_n, q_s_n, q_e_n;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_status       = r_out_status;
    assign o_symbol_found = r_out_found;
    assign o_count        = r_out_count;

    // alphabet in effect: zero acts as one, clamp at the maximum
    always_comb begin
        eff_alpha = VW'(r_alpha_cfg);
        if (r_alpha_cfg == '0) begin
            eff_alpha = VW'(1);
        end else if (VW'(r_alpha_cfg) > VW'(MAX_ALPHABET)) begin
            eff_alpha = VW'(MAX_ALPHABET);
        end
    end

    // levels with a split: smallest k with 2^k >= alphabet
    always_comb begin
        logic found;
        found = 1'b0;
        nlev  = '0;
        for (int k = 0; k <= LEVELS; k++) begin
            if (!found && (((VW + 1)'(1) << k) >= (VW + 1)'(eff_alpha))) begin
                nlev  = DCW'(k);
                found = 1'b1;
            end
        end
    end

    // append checks; a built tree is dropped first
    assign len0        = r_built ? '0 : r_len;
    assign app_bad_sym = (VW'(i_symbol) >= eff_alpha);
    assign app_full    = (len0 >= CW'(MAX_LENGTH));
    assign app_ok      = !app_bad_sym && !app_full;

    // query checks
    assign q_bad_sym = (i_kind == wtra_pkg::KIND_RANK) && (VW'(i_symbol) >= r_alpha_b);
    assign q_bad_pos = (i_kind == wtra_pkg::KIND_RANK) ?
                       (PW'(i_position) >  PW'(r_len)) :
                       (PW'(i_position) >= PW'(r_len));
    assign q_ok      = r_built && !q_bad_sym && !q_bad_pos;

    // one walker, shared by the node check and the element stage
    assign w_sym = (r_state == S_B_NODE) ? r_v : VW'(r_sym_rdata);

    wtra_node_walk #(
        .VW     (VW),
        .LEVELS (LEVELS),
        .DCW    (DCW)
    ) u_walk (
        .i_sym   (w_sym),
        .i_alpha (r_alpha_b),
        .i_depth (r_d),
        .o_lo    (w_lo),
        .o_upper (w_upper)
    );

    assign row_end    = (r_v >= r_alpha_b);
    assign last_level = (r_d == (r_nlev - DCW'(1)));
    assign scan_more  = (r_i < r_len);
    assign emit       = r_rd_vld && (w_lo == r_v);

    // level store write: element entries, then the row total at index len
    always_comb begin
        lvl_we    = 1'b0;
        lvl_waddr = {r_d[DW-1:0], r_j};
        lvl_wdata = {w_upper, r_ones};
        if ((r_state == S_B_NODE) && row_end) begin
            lvl_we    = 1'b1;
            lvl_waddr = {r_d[DW-1:0], r_len};
            lvl_wdata = {1'b0, r_ones};
        end else if (emit) begin
            lvl_we = 1'b1;
        end
    end

    // level store read address per query step
    always_comb begin
        case (r_state)
            S_Q_RP:  lvl_raddr = {r_d[DW-1:0], r_s + r_p};
            S_Q_RE:  lvl_raddr = {r_d[DW-1:0], r_e};
            default: lvl_raddr = {r_d[DW-1:0], r_s};
        endcase
    end

    // one tree level of a query; the count of ones before e arrives now
    always_comb begin
        q_mid   = VW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
        q_bit   = r_q_rank ? (r_q_sym >= q_mid) : r_bsp;
        q_ones  = r_psp - r_ps;
        q_zeros = (r_e - r_s) - (r_lvl_rdata[CW-1:0] - r_ps);
        if (q_bit) begin
            q_p_n  = q_ones;
            q_s_n  = r_s + q_zeros;
            q_e_n  = r_e;
            q_lo_n = q_mid;
            q_hi_n = r_hi;
        end else begin
            q_p_n  = r_p - q_ones;
            q_s_n  = r_s;
            q_e_n  = r_s + q_zeros;
            q_lo_n = r_lo;
            q_hi_n = q_mid;
        end
        q_done = ((q_hi_n - q_lo_n) < VW'(2));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_kind)
                        wtra_pkg::KIND_APPEND: n_state = S_RESP;
                        wtra_pkg::KIND_BUILD: begin
                            n_state = (!r_built && (nlev != '0)) ? S_B_NODE : S_RESP;
                        end
                        default: begin
                            n_state = (q_ok && (r_alpha_b >= VW'(2))) ? S_Q_RS : S_RESP;
                        end
                    endcase
                end
            end
            S_B_NODE: begin
                if (row_end) begin
                    n_state = last_level ? S_RESP : S_B_NODE;
                end else if (w_lo == r_v) begin
                    n_state = S_B_SCAN;
                end
            end
            S_B_SCAN: n_state = scan_more ? S_B_SCAN : S_B_NODE;
            S_Q_RS:   n_state = S_Q_RP;
            S_Q_RP:   n_state = S_Q_RE;
            S_Q_RE:   n_state = S_Q_UPD;
            S_Q_UPD:  n_state = q_done ? S_RESP : S_Q_RS;
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alpha_cfg <= wtra_pkg::ALPHA_RESET;
            r_len       <= '0;
            r_built     <= 1'b0;
            r_alpha_b   <= VW'(1);
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_B_SCAN) && scan_more;
            if (i_cfg_valid) begin
                r_alpha_cfg <= i_cfg_data;
            end
            // output register handshake
            if ((r_state == S_RESP) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc && (i_kind == wtra_pkg::KIND_APPEND)) begin
                r_built <= 1'b0;
                r_len   <= app_ok ? (len0 + CW'(1)) : len0;
            end
            if (in_acc && (i_kind == wtra_pkg::KIND_BUILD) && !r_built) begin
                r_alpha_b <= eff_alpha;
                if (nlev == '0) begin
                    r_built <= 1'b1;
                end
            end
            if ((r_state == S_B_NODE) && row_end && last_level) begin
                r_built <= 1'b1;
            end
        end
    end

    // build and query datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_q_rank <= (i_kind == wtra_pkg::KIND_RANK);
                r_q_sym  <= VW'(i_symbol);
                r_s      <= '0;
                r_e      <= r_len;
                r_lo     <= '0;
                r_hi     <= r_alpha_b;
                r_p      <= CW'(i_position);
                r_d      <= '0;
                r_nlev   <= nlev;
                r_v      <= '0;
                r_ones   <= '0;
                r_j      <= '0;
                r_res_found <= '0;
                case (i_kind)
                    wtra_pkg::KIND_APPEND: begin
                        r_res_status <= app_bad_sym ? wtra_pkg::ST_BAD_SYM :
                                        app_full    ? wtra_pkg::ST_FULL : wtra_pkg::ST_OK;
                        r_res_count  <= app_ok ? wtra_pkg::POS_W'(len0 + CW'(1)) :
                                                 wtra_pkg::POS_W'(len0);
                    end
                    wtra_pkg::KIND_BUILD: begin
                        r_res_status <= wtra_pkg::ST_OK;
                        r_res_count  <= wtra_pkg::POS_W'(r_len);
                    end
                    default: begin
                        r_res_status <= !r_built  ? wtra_pkg::ST_NOT_BUILT :
                                        q_bad_sym ? wtra_pkg::ST_BAD_SYM :
                                        q_bad_pos ? wtra_pkg::ST_BAD_POS : wtra_pkg::ST_OK;
                        r_res_count  <= q_ok ? i_position : '0;
                    end
                endcase
            end
            S_B_NODE: begin
                if (row_end) begin
                    r_d    <= r_d + DCW'(1);
                    r_v    <= '0;
                    r_ones <= '0;
                    r_j    <= '0;
                end else if (w_lo == r_v) begin
                    r_i <= '0;
                end else begin
                    r_v <= r_v + VW'(1);
                end
            end
            S_B_SCAN: begin
                if (scan_more) begin
                    r_i <= r_i + CW'(1);
                end else begin
                    r_v <= r_v + VW'(1);
                end
                if (emit) begin
                    r_j    <= r_j + CW'(1);
                    r_ones <= r_ones + CW'(w_upper);
                end
            end
            S_Q_RP: r_ps <= r_lvl_rdata[CW-1:0];
            S_Q_RE: begin
                r_psp <= r_lvl_rdata[CW-1:0];
                r_bsp <= r_lvl_rdata[CW];
            end
            S_Q_UPD: begin
                r_p  <= q_p_n;
                r_s  <= q_s_n;
                r_e  <= q_e_n;
                r_lo <= q_lo_n;
                r_hi <= q_hi_n;
                r_d  <= r_d + DCW'(1);
                // only access reports the symbol reached
                r_res_found <= r_q_rank ? '0 : wtra_pkg::SYM_W'(q_lo_n);
                r_res_count <= wtra_pkg::POS_W'(q_p_n);
            end
            default: begin
            end
        endcase
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_RESP) && (!r_out_valid || i_out_ready)) begin
            r_out_status <= r_res_status;
            r_out_found  <= r_res_found;
            r_out_count  <= r_res_count;
        end
    end

    // symbol store: written by append, read in order by build
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_kind == wtra_pkg::KIND_APPEND) && app_ok) begin
            r_sym_mem[len0[IW-1:0]] <= SYW'(i_symbol);
        end
        r_sym_rdata <= r_sym_mem[r_i[IW-1:0]];
    end

    // level store: {bit, ones before} per row entry
    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            r_lvl_mem[lvl_waddr] <= lvl_wdata;
        end
        r_lvl_rdata <= r_lvl_mem[lvl_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wtra_checker.sv
// Port-level checks for the wavelet tree rank/access unit, bound to its top level.
// Depends on wtra_pkg and wavelet_tree_rank_access_unit.
`default_nettype none

module wtra_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [wtra_pkg::STATUS_W-1:0]    o_status,
    input wire logic [wtra_pkg::SYM_W-1:0]       o_symbol_found,
    input wire logic [wtra_pkg::POS_W-1:0]       o_count
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_status) && $stable(o_symbol_found) && $stable(o_count))
        else $error("result payload changed while stalled");

    // failed transactions report no symbol
    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != wtra_pkg::ST_OK) |-> (o_symbol_found == '0))
        else $error("symbol reported on a failed transaction");

    // queries rejected as not built or for a bad position report a zero count
    a_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_status == wtra_pkg::ST_NOT_BUILT) ||
                        (o_status == wtra_pkg::ST_BAD_POS)) |-> (o_count == '0))
        else $error("count reported on a rejected query");

endmodule

bind wavelet_tree_rank_access_unit wtra_checker u_wtra_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_symbol_found (o_symbol_found),
    .o_count        (o_count)
);

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the wavelet tree rank/access unit: directed and random
// append/build/rank/access traffic checked against a behavioral model that scans the sequence.
// Depends on wtra_pkg and the wavelet_tree_rank_access_unit RTL.
`default_nettype none

class wt_scoreboard;
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  found;
        logic [12:0] count;
    } t_answer;

    // model state
    logic [3:0]  seq_syms[4096];
    int unsigned seq_len;
    bit          built;
    int unsigned latched_alpha;
    int unsigned alpha_reg;
    t_answer     pending[$];
    int          mismatches;

    function void reset_state();
        seq_len = 0;
        built = 0;
        latched_alpha = 1;
        alpha_reg = 4;
        pending.delete();
        mismatches = 0;
    endfunction

    function int unsigned eff_alpha();
        if (alpha_reg == 0) return 1;
        if (alpha_reg > 16) return 16;
        return alpha_reg;
    endfunction

    // Symbols past a shrunk alphabet behave as the largest one.
    function int unsigned clamp_sym(int unsigned s);
        return (s >= latched_alpha) ? latched_alpha - 1 : s;
    endfunction

    // Note one accepted item and queue its answer.
    function void note_item(logic [1:0] kind, logic [3:0] sym, logic [12:0] pos);
        t_answer a;
        int unsigned c, s;
        a = '0;
        case (kind)
            wtra_pkg::KIND_APPEND: begin
                if (built) begin
                    built = 0;
                    seq_len = 0;
                end
                if (sym >= eff_alpha()) a.status = wtra_pkg::ST_BAD_SYM;
                else if (seq_len >= 4096) a.status = wtra_pkg::ST_FULL;
                else begin
                    seq_syms[seq_len] = sym;
                    seq_len++;
                end
                a.count = seq_len;
            end
            wtra_pkg::KIND_BUILD: begin
                if (!built) begin
                    latched_alpha = eff_alpha();
                    built = 1;
                end
                a.count = seq_len;
            end
            wtra_pkg::KIND_RANK: begin
                if (!built) a.status = wtra_pkg::ST_NOT_BUILT;
                else if (sym >= latched_alpha) a.status = wtra_pkg::ST_BAD_SYM;
                else if (pos > seq_len) a.status = wtra_pkg::ST_BAD_POS;
                else begin
                    c = 0;
                    for (int i = 0; i < pos; i++)
                        if (clamp_sym(seq_syms[i]) == sym) c++;
                    a.count = c;
                end
            end
            default: begin
                if (!built) a.status = wtra_pkg::ST_NOT_BUILT;
                else if (pos >= seq_len) a.status = wtra_pkg::ST_BAD_POS;
                else begin
                    s = clamp_sym(seq_syms[pos]);
                    c = 0;
                    for (int i = 0; i < pos; i++)
                        if (clamp_sym(seq_syms[i]) == s) c++;
                    a.found = s;
                    a.count = c;
                end
            end
        endcase
        pending.push_back(a);
    endfunction

    function void check_result(logic [2:0] st, logic [3:0] fs, logic [12:0] cnt);
        t_answer e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result st=%0d sym=%0d cnt=%0d",
                st, fs, cnt);
            return;
        end
        e = pending.pop_front();
        if (st !== e.status || fs !== e.found || cnt !== e.count) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp st=%0d sym=%0d cnt=%0d, got st=%0d sym=%0d cnt=%0d",
                    e.status, e.found, e.count, st, fs, cnt);
        end
    endfunction
endclass

module tb_top;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic [1:0]  i_kind = '0;
    logic [3:0]  i_symbol = '0;
    logic [12:0] i_position = '0;
    logic        i_out_ready = 0;
    logic        i_cfg_valid = 0;
    logic [4:0]  i_cfg_data = '0;
    logic        o_in_ready, o_out_valid, o_cfg_ready;
    logic [2:0]  o_status;
    logic [3:0]  o_symbol_found;
    logic [12:0] o_count;

    wt_scoreboard tree_sb;
    bit stim_done = 0;

    wavelet_tree_rank_access_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_kind(i_kind), .i_symbol(i_symbol), .i_position(i_position),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_status(o_status), .o_symbol_found(o_symbol_found), .o_count(o_count),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // Send one item, with a random gap beforehand; valid drops only over a gap.
    task automatic send_item(logic [1:0] kind, logic [3:0] sym, logic [12:0] pos);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_in_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind <= kind;
        i_symbol <= sym;
        i_position <= pos;
        i_in_valid <= 1;
        do @(posedge i_clk); while (!o_in_ready);
        tree_sb.note_item(kind, sym, pos);
        @(negedge i_clk);
    endtask

    // Drop valid after the last item of a burst.
    task automatic stop_input();
        i_in_valid <= 0;
    endtask

    // Wait out all results plus a margin, before write_alpha writes the alphabet.
    task automatic drain();
        stop_input();
        while (tree_sb.pending.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_alpha(logic [4:0] val);
        drain();
        i_cfg_data <= val;
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        tree_sb.alpha_reg = val;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // Random sequence: appends, sometimes a rank before the build, one build, then queries.
    task automatic random_round(int n_app, int n_q);
        int unsigned a;
        a = tree_sb.eff_alpha();
        for (int i = 0; i < n_app; i++)
            send_item(wtra_pkg::KIND_APPEND,
                      ($urandom_range(0, 15) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, a - 1),
                      $urandom);
        if ($urandom_range(0, 7) == 0) send_item(wtra_pkg::KIND_RANK, $urandom, $urandom);
        send_item(wtra_pkg::KIND_BUILD, $urandom, $urandom);
        for (int i = 0; i < n_q; i++) begin
            if ($urandom_range(0, 1) == 0)
                send_item(wtra_pkg::KIND_RANK,
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(0, a - 1),
                          ($urandom_range(0, 9) == 0) ? $urandom
                                                     : $urandom_range(0, tree_sb.seq_len));
            else
                send_item(wtra_pkg::KIND_ACCESS, $urandom,
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                              : $urandom_range(0, tree_sb.seq_len ? tree_sb.seq_len - 1 : 0));
        end
    endtask

    // Result side with random stalls.
    initial begin
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(0, 7) == 0) || ($urandom_range(0, 7) > 2);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && i_out_ready)
            tree_sb.check_result(o_status, o_symbol_found, o_count);

    initial begin
        tree_sb = new();
        tree_sb.reset_state();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: queries before build, bad symbols, empty tree, extremes.
        send_item(wtra_pkg::KIND_RANK, 0, 0);
        send_item(wtra_pkg::KIND_ACCESS, 4'hF, 13'h1FFF);
        send_item(wtra_pkg::KIND_BUILD, 0, 0);
        send_item(wtra_pkg::KIND_RANK, 0, 0);
        send_item(wtra_pkg::KIND_ACCESS, 0, 0);
        send_item(wtra_pkg::KIND_APPEND, 3, 0);
        send_item(wtra_pkg::KIND_APPEND, 4'hF, 13'h1FFF);
        send_item(wtra_pkg::KIND_APPEND, 0, 0);
        send_item(wtra_pkg::KIND_APPEND, 2, 0);
        send_item(wtra_pkg::KIND_BUILD, 0, 0);
        send_item(wtra_pkg::KIND_BUILD, 0, 0);
        send_item(wtra_pkg::KIND_RANK, 3, 3);
        send_item(wtra_pkg::KIND_RANK, 2, 4);
        send_item(wtra_pkg::KIND_RANK, 4, 0);
        send_item(wtra_pkg::KIND_ACCESS, 0, 2);
        send_item(wtra_pkg::KIND_ACCESS, 0, 3);
        send_item(wtra_pkg::KIND_RANK, 0, 13'h1FFF);
        // append after build drops the sequence even when rejected
        send_item(wtra_pkg::KIND_APPEND, 4'hF, 0);
        send_item(wtra_pkg::KIND_BUILD, 0, 0);
        send_item(wtra_pkg::KIND_ACCESS, 0, 0);

        // shrink alphabet between append and build
        write_alpha(16);
        for (int i = 0; i < 8; i++) send_item(wtra_pkg::KIND_APPEND, 15 - 2 * i, 0);
        write_alpha(3);
        send_item(wtra_pkg::KIND_BUILD, 0, 0);
        for (int i = 0; i < 4; i++) send_item(wtra_pkg::KIND_ACCESS, 0, i);
        send_item(wtra_pkg::KIND_RANK, 2, 8);

        // alphabet of zero acts as one
        write_alpha(0);
        random_round(6, 6);
        write_alpha(5'h1F);
        random_round(20, 20);
        write_alpha(1);
        random_round(5, 5);

        // sender holds off until all results are back
        stop_input();
        while (tree_sb.pending.size() != 0) @(negedge i_clk);

        for (int r = 0; r < 12; r++) begin
            write_alpha($urandom_range(0, 31));
            random_round($urandom_range(1, 20), $urandom_range(5, 20));
        end
        write_alpha(4);
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (tree_sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (tree_sb.mismatches == 0)
            $display("PASS wavelet_tree_rank_access_unit");
        else
            $display("FAIL wavelet_tree_rank_access_unit");
        $finish;
    end

    initial begin
        #20000000;
        $display("FAIL wavelet_tree_rank_access_unit");
        $finish;
    end
endmodule

`default_nettype wire
